FILE: rtl/core/srtl_pkg.sv
`default_nettype none
package srtl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_BITS  = 16;

  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 11;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int IN_BITS     = OPCODE_W + VALUE_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_W + POS_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Match encoder: a registered OR tree, TREE_FAN leaves per node.
  localparam int TREE_FAN   = 32;
  localparam int TREE_NODES = (TABLE_DEPTH + TREE_FAN - 1) / TREE_FAN;

  function automatic int tree_levels();
    int n;
    int l;
    n = TREE_NODES;
    l = 1;
    while (n > 1) begin
      n = (n + TREE_FAN - 1) / TREE_FAN;
      l = l + 1;
    end
    return l;
  endfunction

  localparam int TREE_LEVELS = tree_levels();
  localparam int LVL_W       = $clog2(TREE_LEVELS + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_FOUND     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_CLEARED   = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_QUERY
  } state_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic [VALUE_BITS-1:0] entry;
    logic                  gt;   // invalid, or entry above the insert key
    logic                  ge;   // valid and entry not below the query key
  } link_t;

endpackage
`default_nettype wire

FILE: rtl/core/srtl_cell.sv
`default_nettype none
module srtl_cell (
  input  wire                             clk,
  input  wire                             shift_en,
  input  wire  [srtl_pkg::VALUE_BITS-1:0] ins_key,
  input  wire  [srtl_pkg::VALUE_BITS-1:0] qry_key,
  input  wire                             valid,
  input  wire  srtl_pkg::link_t           left,
  output srtl_pkg::link_t                 right,
  output logic                            hit
);
  import srtl_pkg::*;

  logic [VALUE_BITS-1:0] entry;
  logic                  gt;
  logic                  ge;

  assign gt = !valid || (entry > ins_key);
  assign ge = valid && (entry >= qry_key);

  // First cell at or above the key, and equal to it.
  assign hit = ge && !left.ge && (entry == qry_key);

  assign right.entry = entry;
  assign right.gt    = gt;
  assign right.ge    = ge;

  // Open a slot: cells above the key take their neighbor's entry, the
  // first of them takes the key.
  always_ff @(posedge clk) begin
    if (shift_en && gt) begin
      entry <= left.gt ? left.entry : ins_key;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/srtl_hit_tree.sv
`default_nettype none
module srtl_hit_tree (
  input  wire                         clk,
  input  wire  [srtl_pkg::TABLE_DEPTH-1:0] hit,
  output logic                        found,
  output logic [srtl_pkg::IDX_W-1:0]  idx
);
  import srtl_pkg::*;

  logic             node_hit [TREE_LEVELS][TREE_NODES];
  logic [IDX_W-1:0] node_idx [TREE_LEVELS][TREE_NODES];

  // Leaf level: OR of one group of cells, with the index of the one hit.
  for (genvar j = 0; j < TREE_NODES; j++) begin : g_leaf
    logic             h;
    logic [IDX_W-1:0] x;
    always_comb begin
      h = 1'b0;
      x = '0;
      for (int k = 0; k < TREE_FAN; k++) begin
        if (j * TREE_FAN + k < TABLE_DEPTH) begin
          if (hit[j * TREE_FAN + k]) begin
            h = 1'b1;
            x = x | IDX_W'(j * TREE_FAN + k);
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      node_hit[0][j] <= h;
      node_idx[0][j] <= x;
    end
  end

  // Upper levels: at most one hit is set, so indices merge by OR.
  for (genvar l = 1; l < TREE_LEVELS; l++) begin : g_level
    for (genvar j = 0; j < TREE_NODES; j++) begin : g_node
      logic             h;
      logic [IDX_W-1:0] x;
      always_comb begin
        h = 1'b0;
        x = '0;
        for (int k = 0; k < TREE_FAN; k++) begin
          if (j * TREE_FAN + k < TREE_NODES) begin
            h = h | node_hit[l-1][j * TREE_FAN + k];
            x = x | node_idx[l-1][j * TREE_FAN + k];
          end
        end
      end
      always_ff @(posedge clk) begin
        node_hit[l][j] <= h;
        node_idx[l][j] <= x;
      end
    end
  end

  assign found = node_hit[TREE_LEVELS-1][0];
  assign idx   = node_idx[TREE_LEVELS-1][0];

endmodule
`default_nettype wire

FILE: rtl/core/sorted_table_rank_lookup_top.sv
`default_nettype none
// Channel  Dir  tdata fields (low bit up)                    tuser
// s_*      in   opcode[1:0], value[17:2], zero pad to 24     -
// m_*      out  status[2:0], position[13:3], zero pad to 16  -
//
// Clear and insert complete in the accepting cycle; their result is loaded
// into the output register on the same edge. A query passes through the
// registered match tree over the cells, then waits for a free output register.
// Reset clears the state, entry count and output valid; cell contents need no clearing.
// A query is taken while a result waits; clear and insert wait for a free
// output register. Items come in one at a time.
module sorted_table_rank_lookup_top (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [srtl_pkg::IN_TDATA_W-1:0]  s_tdata,   // opcode, value
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [srtl_pkg::OUT_TDATA_W-1:0] m_tdata    // status, position
);
  import srtl_pkg::*;

  state_t                state, state_next;
  logic [LVL_W-1:0]      cnt, cnt_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [VALUE_BITS-1:0] qkey, qkey_next;
  logic                  out_valid, out_valid_next;
  logic [STATUS_W-1:0]   out_status, out_status_next;
  logic [POS_W-1:0]      out_pos, out_pos_next;

  logic [OPCODE_W-1:0]   in_op;
  logic [VALUE_BITS-1:0] in_value;
  logic                  accept;
  logic                  out_free;
  logic                  shift_en;

  link_t                   link [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0]  hit;
  logic                    found;
  logic [IDX_W-1:0]        found_idx;

  assign in_op    = s_tdata[OPCODE_W-1:0];
  assign in_value = s_tdata[OPCODE_W +: VALUE_BITS];
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  assign link[0] = '{entry: '0, gt: 1'b0, ge: 1'b0};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    srtl_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .ins_key  (in_value),
      .qry_key  (qkey),
      .valid    (CNT_W'(i) < count),
      .left     (link[i]),
      .right    (link[i+1]),
      .hit      (hit[i])
    );
  end

  srtl_hit_tree u_tree (
    .clk   (clk),
    .hit   (hit),
    .found (found),
    .idx   (found_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    qkey       <= qkey_next;
    out_status <= out_status_next;
    out_pos    <= out_pos_next;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    count_next      = count;
    qkey_next       = qkey;
    out_valid_next  = out_valid && !m_tready;
    out_status_next = out_status;
    out_pos_next    = out_pos;
    s_tready        = 1'b0;
    shift_en        = 1'b0;

    case (state)
      S_IDLE: begin
        s_tready = out_free || !(in_op == OP_CLEAR || in_op == OP_INSERT);
        if (accept) begin
          case (in_op)
            OP_CLEAR: begin
              count_next      = '0;
              out_valid_next  = 1'b1;
              out_status_next = STAT_CLEARED;
              out_pos_next    = '0;
            end
            OP_INSERT: begin
              out_valid_next = 1'b1;
              out_pos_next   = '0;
              if (count == CNT_W'(TABLE_DEPTH)) begin
                out_status_next = STAT_FULL;
              end else begin
                shift_en        = 1'b1;
                count_next      = count + 1'b1;
                out_status_next = STAT_INSERTED;
              end
            end
            OP_QUERY: begin
              qkey_next  = in_value;
              cnt_next   = '0;
              state_next = S_QUERY;
            end
            default: begin
              // unused opcode: drop with no result
            end
          endcase
        end
      end
      S_QUERY: begin
        if (cnt != LVL_W'(TREE_LEVELS)) begin
          cnt_next = cnt + 1'b1;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          if (found) begin
            out_status_next = STAT_FOUND;
            out_pos_next    = POS_W'({1'b0, found_idx} + 1'b1);
          end else begin
            out_status_next = STAT_NOT_FOUND;
            out_pos_next    = '0;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'({out_pos, out_status});

endmodule
`default_nettype wire

FILE: verif/sorted_table_rank_lookup_checker.sv
module sorted_table_rank_lookup_checker
  import srtl_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  input  wire                    s_tready,
  input  wire [IN_TDATA_W-1:0]   s_tdata,    // opcode, value
  input  wire                    m_tvalid,
  input  wire                    m_tready,
  input  wire [OUT_TDATA_W-1:0]  m_tdata,    // status, position
  output int                     fail_count,
  output int                     pending_count,
  output int                     result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] position;
  } rank_result_t;

  rank_result_t          expected_ranks[$];
  logic [VALUE_BITS-1:0] ranked_vals[$];

  // First index whose entry is above key (past_equal) or not below key.
  function automatic int search_rank(input logic [VALUE_BITS-1:0] key, input bit past_equal);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = ranked_vals.size();
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (ranked_vals[mid] < key || (past_equal && ranked_vals[mid] == key)) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  function automatic void predict_rank(input logic [OPCODE_W-1:0] op,
                                       input logic [VALUE_BITS-1:0] key);
    rank_result_t r;
    int at;
    r.position = '0;
    case (op)
      OP_CLEAR: begin
        ranked_vals.delete();
        r.status = STAT_CLEARED;
        expected_ranks.insert(expected_ranks.size(), r);
      end
      OP_INSERT: begin
        if (ranked_vals.size() >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // place after any equal copies
          at = search_rank(key, 1'b1);
          ranked_vals.insert(at, key);
          r.status = STAT_INSERTED;
        end
        expected_ranks.insert(expected_ranks.size(), r);
      end
      OP_QUERY: begin
        at = search_rank(key, 1'b0);
        if (at < ranked_vals.size() && ranked_vals[at] == key) begin
          r.status   = STAT_FOUND;
          r.position = POS_W'(at + 1);
        end else begin
          r.status = STAT_NOT_FOUND;
        end
        expected_ranks.insert(expected_ranks.size(), r);
      end
      default: ;  // unused opcode: drop without a result
    endcase
  endfunction

  always @(posedge clk) begin : watch
    rank_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_rank(s_tdata[OPCODE_W-1:0], s_tdata[OPCODE_W +: VALUE_BITS]);
      end
      if (m_tvalid && m_tready) begin
        result_count++;
        if (expected_ranks.size() == 0) begin
          $error("result with no request waiting: tdata %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_ranks[0];
          expected_ranks.delete(0);
          if (m_tdata[STATUS_W-1:0] !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status,
                   m_tdata[STATUS_W-1:0]);
            fail_count++;
          end
          if (m_tdata[STATUS_W +: POS_W] !== want.position) begin
            $error("position mismatch: expected %0d, got %0d", want.position,
                   m_tdata[STATUS_W +: POS_W]);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_ranks.size();
  end

endmodule

FILE: verif/sorted_table_rank_lookup_top_tb.sv
module sorted_table_rank_lookup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srtl_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 720;
  localparam int LONG_HOLD       = 300;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_count;
  int pending_count;
  int result_count;
  int requests_sent = 0;
  int holds_done = 0;
  bit sender_calm = 1'b0;
  logic [VALUE_BITS-1:0] loaded_vals[$];

  always #6 clk = ~clk;

  sorted_table_rank_lookup_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sorted_table_rank_lookup_checker rank_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly values already loaded or their neighbors, some anywhere.
  function automatic logic [VALUE_BITS-1:0] pick_probe();
    int r;
    logic [VALUE_BITS-1:0] v;
    r = $urandom_range(0, 9);
    if (loaded_vals.size() == 0 || r < 2) return VALUE_BITS'($urandom);
    v = loaded_vals[$urandom_range(0, loaded_vals.size() - 1)];
    if (r < 6) return v;
    if (r < 8) return v + 1'b1;
    return v - 1'b1;
  endfunction

  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic [VALUE_BITS-1:0] value);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({value, op});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op != OP_UNUSED) requests_sent++;
    if (op == OP_CLEAR) begin
      loaded_vals.delete();
    end else if (op == OP_INSERT && loaded_vals.size() < TABLE_DEPTH) begin
      loaded_vals.insert(loaded_vals.size(), value);
    end
  endtask

  // Hold the input until every outstanding result has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  // Receiver: random stalls, calm windows, and long hold-offs to back up the input.
  initial begin : result_sink
    int stall;
    int cycle;
    stall = 0;
    cycle = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cycle++;
      if (stall == 0 && holds_done < 2 && result_count >= 250 + holds_done * 300) begin
        holds_done++;
        stall = LONG_HOLD;
      end else if (stall == 0 && (cycle / 200) % 3 != 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int base_sent;
    int n;
    int span;
    logic [VALUE_BITS-1:0] base;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, duplicates, value above all, unused opcode.
    send_request(OP_QUERY, 16'h0000);
    send_request(OP_QUERY, 16'hFFFF);
    send_request(OP_UNUSED, 16'hFFFF);
    send_request(OP_INSERT, 16'h8000);
    send_request(OP_INSERT, 16'h0000);
    send_request(OP_INSERT, 16'hFFFF);
    send_request(OP_INSERT, 16'h8000);
    send_request(OP_INSERT, 16'h7FFF);
    send_request(OP_QUERY, 16'h0000);
    send_request(OP_QUERY, 16'hFFFF);
    send_request(OP_QUERY, 16'h8000);
    send_request(OP_QUERY, 16'h7FFF);
    send_request(OP_QUERY, 16'h8001);
    send_request(OP_CLEAR, 16'hFFFF);
    send_request(OP_INSERT, 16'h0100);
    send_request(OP_QUERY, 16'h0101);
    send_request(OP_QUERY, 16'h00FF);
    send_request(OP_UNUSED, 16'h0000);
    send_request(OP_QUERY, 16'h0100);
    send_request(OP_CLEAR, 16'h0000);
    send_request(OP_CLEAR, 16'h5A5A);
    send_request(OP_QUERY, 16'h0100);
    drain_results();

    base_sent = requests_sent;
    while (requests_sent - base_sent < RANDOM_REQUESTS) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) send_request(OP_CLEAR, VALUE_BITS'($urandom));
        base = VALUE_BITS'($urandom);
        span = $urandom_range(0, 1) ? $urandom_range(0, 15) : 16'hFFFF;
        n = $urandom_range(1, 40);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            send_request(OP_QUERY, pick_probe());
          end else begin
            send_request(OP_INSERT, VALUE_BITS'(base + $urandom_range(0, span)));
          end
        end
        repeat ($urandom_range(1, 20)) send_request(OP_QUERY, pick_probe());
      end else begin
        // noise, unused opcode included
        repeat ($urandom_range(1, 10)) send_request(OPCODE_W'($urandom_range(0, 3)),
                                                    VALUE_BITS'($urandom));
      end
      if ($urandom_range(0, 7) == 0) drain_results();
    end
    sender_calm = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    $display("Run covered %0d requests with duplicates, extremes and clears, %0d results checked,",
             requests_sent, result_count);
    $display("with %0d long output hold-offs and random gaps on both channels.", holds_done);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** sorted_table_rank_lookup_top: PASSED **");
    end else begin
      $display("** sorted_table_rank_lookup_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("** sorted_table_rank_lookup_top: FAILED **");
    $finish;
  end

endmodule
